>>> hw/rtl/htu_pkg.sv
// Shared types, constants and helper functions for the homogeneous transform unit.
// No dependencies; every other file in hw/rtl but htu_checker.sv imports this package.
package htu_pkg;

  // Fixed-point format of coefficients, vectors and results
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 32;
  localparam int TRIG_W    = 18;
  localparam int TRIG_FRAC = 16;
  localparam int DIM       = 4;
  localparam int NUM_COEF  = DIM * DIM;
  localparam int IDX_W     = $clog2(NUM_COEF);

  // Datapath widths: 32x32 product, sum of two, sum of four
  localparam int PROD_W = 2 * COEF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // Command queue between decode and execute
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TRIG_UP = (FRAC_BITS >= TRIG_FRAC) ? FRAC_BITS - TRIG_FRAC : 0;
  localparam int TRIG_DN = (FRAC_BITS <  TRIG_FRAC) ? TRIG_FRAC - FRAC_BITS : 0;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t mat_t [NUM_COEF];
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t ONE      = coef_t'(64'sd1 <<< FRAC_BITS);

  localparam sum_t SAT_HI   = {{(SUM_W-COEF_W){1'b0}}, COEF_MAX};
  localparam sum_t SAT_LO   = ~SAT_HI;
  localparam sum_t RND_BIAS = sum_t'((67'sd1 <<< FRAC_BITS) - 67'sd1);

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_WRITE      = 3'd1,
    OP_IDENT      = 3'd2,
    OP_ROTATE     = 3'd3,
    OP_TRANSLATE  = 3'd4,
    OP_TRANSPOSE  = 3'd5,
    OP_NEG_TRANS  = 3'd6,
    OP_XFORM      = 3'd7
  } op_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // One decoded command as it sits in the queue
  typedef struct packed {
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] axis;
    coef_t      value;
    coef_t      cos_s;
    coef_t      sin_s;
    coef_t      sin_n;
    coef_t      vx;
    coef_t      vy;
    coef_t      vz;
    coef_t      vw;
  } cmd_t;

  // Negate, with the most negative value mapped to the most positive
  function automatic coef_t neg_sat(input coef_t v);
    neg_sat = (v == COEF_MIN) ? COEF_MAX : -v;
  endfunction

  // Q2.16 trig term to FRAC_BITS fraction bits, truncating toward zero
  function automatic coef_t trig_scale(input logic signed [TRIG_W-1:0] t);
    coef_t ext;
    coef_t mag;
    ext = coef_t'(t);
    mag = ext[COEF_W-1] ? -ext : ext;
    if (FRAC_BITS >= TRIG_FRAC) begin
      trig_scale = ext <<< TRIG_UP;
    end else if (ext[COEF_W-1]) begin
      trig_scale = -(mag >>> TRIG_DN);
    end else begin
      trig_scale = mag >>> TRIG_DN;
    end
  endfunction

endpackage

>>> hw/rtl/htu_front.sv
// Decode stage: classifies an input beat and prepares its command for the queue.
// Depends on htu_pkg.
module htu_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    operation,
  input  logic [1:0]                    row,
  input  logic [1:0]                    col,
  input  logic signed [31:0]            value,
  input  logic [1:0]                    axis,
  input  logic signed [17:0]            cosine,
  input  logic signed [17:0]            sine,
  input  logic signed [31:0]            vec_x,
  input  logic signed [31:0]            vec_y,
  input  logic signed [31:0]            vec_z,
  input  logic signed [31:0]            vec_w,
  input  logic                          queue_ready,
  output logic                          push,
  output htu_pkg::cmd_t                 cmd
);
  import htu_pkg::*;

  coef_t sin_scaled;

  assign in_ready   = queue_ready;
  assign push       = in_valid && queue_ready;
  assign sin_scaled = trig_scale(sine);

  always_comb begin
    cmd       = '0;
    cmd.op    = op_t'(operation);
    cmd.row   = row;
    cmd.col   = col;
    cmd.axis  = axis;
    cmd.value = value;
    cmd.cos_s = trig_scale(cosine);
    cmd.sin_s = sin_scaled;
    cmd.sin_n = neg_sat(sin_scaled);
    cmd.vx    = vec_x;
    cmd.vy    = vec_y;
    cmd.vz    = vec_z;
    cmd.vw    = vec_w;
  end

endmodule

>>> hw/rtl/htu_queue.sv
// Short command FIFO that decouples decode from execute.
// Depends on htu_pkg.
module htu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  htu_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output htu_pkg::cmd_t head_cmd
);
  import htu_pkg::*;

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = (count != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/htu_matrix.sv
// Execute side: holds the 4x4 matrix, applies matrix commands, issues transforms.
// Depends on htu_pkg.
module htu_matrix (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  htu_pkg::cmd_t head_cmd,
  input  logic          advance,
  output logic          pop,
  output logic          issue,
  output htu_pkg::mat_t mat
);
  import htu_pkg::*;

  mat_t m;
  mat_t m_next;
  logic is_xform;
  logic apply;

  assign is_xform = (head_cmd.op == OP_XFORM);
  // matrix commands retire at once; a transform waits for the pipeline
  assign pop   = head_valid && (!is_xform || advance);
  assign issue = head_valid && is_xform && advance;
  assign apply = head_valid && !is_xform;
  assign mat   = m;

  always_comb begin
    m_next = m;
    if (apply) begin
      case (head_cmd.op)
        OP_CLEAR: begin
          for (int k = 0; k < NUM_COEF; k++) m_next[k] = '0;
        end
        OP_WRITE: begin
          m_next[{head_cmd.row, head_cmd.col}] = head_cmd.value;
        end
        OP_IDENT: begin
          for (int k = 0; k < NUM_COEF; k++) m_next[k] = '0;
          for (int d = 0; d < DIM; d++) m_next[d * (DIM + 1)] = ONE;
        end
        OP_ROTATE: begin
          for (int k = 0; k < NUM_COEF; k++) m_next[k] = '0;
          case (head_cmd.axis)
            AXIS_X: begin
              m_next[0]  = ONE;            m_next[15] = ONE;
              m_next[5]  = head_cmd.cos_s; m_next[10] = head_cmd.cos_s;
              m_next[9]  = head_cmd.sin_n; m_next[6]  = head_cmd.sin_s;
            end
            AXIS_Y: begin
              m_next[0]  = head_cmd.cos_s; m_next[10] = head_cmd.cos_s;
              m_next[5]  = ONE;            m_next[15] = ONE;
              m_next[8]  = head_cmd.sin_s; m_next[2]  = head_cmd.sin_n;
            end
            AXIS_Z: begin
              m_next[0]  = head_cmd.cos_s; m_next[5]  = head_cmd.cos_s;
              m_next[10] = ONE;            m_next[15] = ONE;
              m_next[4]  = head_cmd.sin_n; m_next[1]  = head_cmd.sin_s;
            end
            default: begin
              // no such axis: matrix stays all zero
            end
          endcase
        end
        OP_TRANSLATE: begin
          for (int k = 0; k < NUM_COEF; k++) m_next[k] = '0;
          for (int d = 0; d < DIM; d++) m_next[d * (DIM + 1)] = ONE;
          if (head_cmd.axis != 2'd3) begin
            m_next[{2'b11, head_cmd.axis}] = head_cmd.value;
          end
        end
        OP_TRANSPOSE: begin
          for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
              m_next[IDX_W'(r * DIM + c)] = m[IDX_W'(c * DIM + r)];
            end
          end
        end
        OP_NEG_TRANS: begin
          for (int c = 0; c < DIM - 1; c++) begin
            m_next[IDX_W'(3 * DIM + c)] = neg_sat(m[IDX_W'(3 * DIM + c)]);
          end
        end
        default: begin
          m_next = m;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COEF; k++) m[k] <= '0;
    end else begin
      m <= m_next;
    end
  end

endmodule

>>> hw/rtl/htu_mac.sv
// Transform pipeline: 16 multiplies, two adder levels, round toward zero, saturate.
// Depends on htu_pkg. Ends in the output register that the sink handshakes with.
module htu_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                issue,
  input  htu_pkg::cmd_t       issue_cmd,
  input  htu_pkg::mat_t       mat,
  input  logic                out_ready,
  output logic                advance,
  output logic                out_valid,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [31:0]  out_w,
  output logic                overflow
);
  import htu_pkg::*;

  coef_t vec [DIM];
  prod_t prod [DIM][DIM];
  pair_t pair [DIM][2];
  sum_t  sum  [DIM];
  sum_t  biased [DIM];
  sum_t  quot [DIM];
  coef_t res_next [DIM];
  logic  [DIM-1:0] sat_hit;
  coef_t res [DIM];
  logic  v1, v2, v3;

  assign vec[0] = issue_cmd.vx;
  assign vec[1] = issue_cmd.vy;
  assign vec[2] = issue_cmd.vz;
  assign vec[3] = issue_cmd.vw;

  // whole pipeline moves unless a result sits unclaimed
  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= issue;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          prod[i][j] <= vec[j] * mat[IDX_W'(j * DIM + i)];
        end
        pair[i][0] <= pair_t'(prod[i][0]) + pair_t'(prod[i][1]);
        pair[i][1] <= pair_t'(prod[i][2]) + pair_t'(prod[i][3]);
        sum[i]     <= sum_t'(pair[i][0]) + sum_t'(pair[i][1]);
        res[i]     <= res_next[i];
      end
      overflow <= |sat_hit;
    end
  end

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      biased[i] = sum[i] + (sum[i][SUM_W-1] ? RND_BIAS : '0);
      quot[i]   = biased[i] >>> FRAC_BITS;
      if (quot[i] > SAT_HI) begin
        res_next[i] = COEF_MAX;
        sat_hit[i]  = 1'b1;
      end else if (quot[i] < SAT_LO) begin
        res_next[i] = COEF_MIN;
        sat_hit[i]  = 1'b1;
      end else begin
        res_next[i] = quot[i][COEF_W-1:0];
        sat_hit[i]  = 1'b0;
      end
    end
  end

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule

>>> hw/rtl/homogeneous_transform_unit.sv
// Top level of the homogeneous transform unit: decode, command queue, matrix, MAC.
// Depends on htu_pkg, htu_front, htu_queue, htu_matrix, htu_mac.
//
//   channel | handshake            | beat contents
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_ready  | operation, row, col, value, axis, cosine, sine,
//           |                      | vec_x, vec_y, vec_z, vec_w
//   out     | out_valid/ out_ready | out_x, out_y, out_z, out_w, overflow
//
// One input beat per cycle is taken while the four-entry command queue has room.
// A transform beat passes the queue, the product register, two adder levels and the
// round/saturate register before out_valid; matrix commands retire once at the queue head.
// Commands execute strictly in order, so a transform sees every earlier matrix update.
// Reset (synchronous) clears the matrix to zero, empties the queue and the pipeline.
// A result held on out_ready low freezes the MAC pipeline; the queue takes beats until full.
module homogeneous_transform_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  input  logic [1:0]         axis,
  input  logic signed [17:0] cosine,
  input  logic signed [17:0] sine,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] vec_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic               overflow
);
  import htu_pkg::*;

  // front to queue
  logic queue_ready;
  logic push;
  cmd_t push_cmd;

  // queue head to execute side
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // matrix to MAC
  logic issue;
  mat_t mat;
  logic advance;

  htu_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .row         (row),
    .col         (col),
    .value       (value),
    .axis        (axis),
    .cosine      (cosine),
    .sine        (sine),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .vec_z       (vec_z),
    .vec_w       (vec_w),
    .queue_ready (queue_ready),
    .push        (push),
    .cmd         (push_cmd)
  );

  htu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // the matrix is read by a transform in the same cycle it leaves the queue
  htu_matrix u_matrix (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .advance    (advance),
    .pop        (pop),
    .issue      (issue),
    .mat        (mat)
  );

  htu_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .issue_cmd (head_cmd),
    .mat       (mat),
    .out_ready (out_ready),
    .advance   (advance),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .overflow  (overflow)
  );

endmodule

>>> hw/rtl/htu_checker.sv
// Port-level checks for the homogeneous transform unit, bound to its top level.
// No package dependency.
module htu_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         operation,
  input logic [1:0]         row,
  input logic [1:0]         col,
  input logic signed [31:0] value,
  input logic [1:0]         axis,
  input logic signed [17:0] cosine,
  input logic signed [17:0] sine,
  input logic signed [31:0] vec_x,
  input logic signed [31:0] vec_y,
  input logic signed [31:0] vec_z,
  input logic signed [31:0] vec_w,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic signed [31:0] out_w,
  input logic               overflow
);

  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_w) && $stable(overflow))
    else $error("result beat changed while stalled");

  // overflow only with a component clamped to a rail
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> out_x == SMAX || out_x == SMIN || out_y == SMAX
      || out_y == SMIN || out_z == SMAX || out_z == SMIN || out_w == SMAX
      || out_w == SMIN)
    else $error("overflow without a saturated component");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("queue not ready right after reset");

endmodule

bind homogeneous_transform_unit htu_port_checks u_htu_checker (.*);

>>> sim/htu_checker.sv
`timescale 1ns / 1ps
// Checker for homogeneous_transform_unit: mirrors the matrix from accepted input beats,
// predicts every transform result and compares it with the out channel.
// Depends on htu_pkg (op_t, coef_t, FRAC_BITS, COEF_MAX, COEF_MIN, ONE, AXIS_*).
module htu_checker
  import htu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  input  logic [1:0]         axis,
  input  logic signed [17:0] cosine,
  input  logic signed [17:0] sine,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] vec_w,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic signed [31:0] out_w,
  input  logic               overflow,
  output int                 pending,
  output int                 mismatches
);

  // wide enough for the exact sum of four 32x32 products
  typedef logic signed [71:0] acc_t;

  typedef struct packed {
    coef_t x;
    coef_t y;
    coef_t z;
    coef_t w;
    logic  ovf;
  } xform_out_t;

  localparam int TRIG_SHL = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int TRIG_SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  coef_t      mat [16] = '{default: '0};
  xform_out_t expected_xforms [$];

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  function automatic coef_t flip_sat(input coef_t v);
    return (v == COEF_MIN) ? COEF_MAX : -v;
  endfunction

  // Q2.16 term to FRAC_BITS, truncating toward zero
  function automatic coef_t trig_to_q(input logic signed [17:0] t);
    coef_t ext;
    ext = {{14{t[17]}}, t};
    if (TRIG_SHR == 0) return ext <<< TRIG_SHL;
    if (ext < 0) return -((-ext) >>> TRIG_SHR);
    return ext >>> TRIG_SHR;
  endfunction

  function automatic void load_unit();
    foreach (mat[k]) mat[k] = (k % 5 == 0) ? ONE : '0;
  endfunction

  always @(posedge clk) begin : matrix_model
    coef_t      c_q;
    coef_t      s_q;
    coef_t      tmp;
    coef_t      vin [4];
    coef_t      comp [4];
    acc_t       acc;
    acc_t       q;
    xform_out_t exp_r;
    xform_out_t got;
    int         i;
    int         j;

    if (rst) begin
      foreach (mat[k]) mat[k] = '0;
      expected_xforms.delete();
    end else begin
      // result side first: a beat taken now can never leave at the same edge
      if (out_valid && out_ready) begin
        got = '{out_x, out_y, out_z, out_w, overflow};
        if (expected_xforms.size() == 0) begin
          $error("result beat with no transform outstanding: out_x=%0d", out_x);
          mismatches++;
        end else begin
          exp_r = expected_xforms.pop_front();
          if (got.x !== exp_r.x) begin
            $error("out_x: expected %0d, got %0d", exp_r.x, got.x);
            mismatches++;
          end
          if (got.y !== exp_r.y) begin
            $error("out_y: expected %0d, got %0d", exp_r.y, got.y);
            mismatches++;
          end
          if (got.z !== exp_r.z) begin
            $error("out_z: expected %0d, got %0d", exp_r.z, got.z);
            mismatches++;
          end
          if (got.w !== exp_r.w) begin
            $error("out_w: expected %0d, got %0d", exp_r.w, got.w);
            mismatches++;
          end
          if (got.ovf !== exp_r.ovf) begin
            $error("overflow: expected %0d, got %0d", exp_r.ovf, got.ovf);
            mismatches++;
          end
        end
      end

      if (in_valid && in_ready) begin
        case (op_t'(operation))
          OP_CLEAR: foreach (mat[k]) mat[k] = '0;
          OP_WRITE: mat[{row, col}] = value;
          OP_IDENT: load_unit();
          OP_ROTATE: begin
            c_q = trig_to_q(cosine);
            s_q = trig_to_q(sine);
            foreach (mat[k]) mat[k] = '0;
            case (axis)
              AXIS_X: begin
                mat[0]  = ONE;  mat[15] = ONE;
                mat[5]  = c_q;  mat[10] = c_q;
                mat[6]  = s_q;  mat[9]  = flip_sat(s_q);
              end
              AXIS_Y: begin
                mat[5]  = ONE;  mat[15] = ONE;
                mat[0]  = c_q;  mat[10] = c_q;
                mat[8]  = s_q;  mat[2]  = flip_sat(s_q);
              end
              AXIS_Z: begin
                mat[10] = ONE;  mat[15] = ONE;
                mat[0]  = c_q;  mat[5]  = c_q;
                mat[1]  = s_q;  mat[4]  = flip_sat(s_q);
              end
              default: ;  // no axis: matrix stays all zero
            endcase
          end
          OP_TRANSLATE: begin
            load_unit();
            if (axis inside {AXIS_X, AXIS_Y, AXIS_Z}) mat[12 + axis] = value;
          end
          OP_TRANSPOSE: begin
            for (i = 0; i < 4; i++)
              for (j = i + 1; j < 4; j++) begin
                tmp          = mat[i*4 + j];
                mat[i*4 + j] = mat[j*4 + i];
                mat[j*4 + i] = tmp;
              end
          end
          OP_NEG_TRANS: for (i = 12; i < 15; i++) mat[i] = flip_sat(mat[i]);
          OP_XFORM: begin
            vin[0] = vec_x; vin[1] = vec_y; vin[2] = vec_z; vin[3] = vec_w;
            exp_r.ovf = 1'b0;
            for (i = 0; i < 4; i++) begin
              acc = '0;
              for (j = 0; j < 4; j++) acc += acc_t'(vin[j]) * acc_t'(mat[j*4 + i]);
              // exact sum, truncated toward zero, then saturated
              q = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
              if (q > acc_t'(COEF_MAX)) begin
                comp[i] = COEF_MAX;
                exp_r.ovf = 1'b1;
              end else if (q < acc_t'(COEF_MIN)) begin
                comp[i] = COEF_MIN;
                exp_r.ovf = 1'b1;
              end else begin
                comp[i] = coef_t'(q);
              end
            end
            exp_r.x = comp[0]; exp_r.y = comp[1]; exp_r.z = comp[2]; exp_r.w = comp[3];
            expected_xforms.push_back(exp_r);
          end
          default: ;
        endcase
      end
    end
    pending <= expected_xforms.size();
  end

endmodule

>>> sim/tb_homogeneous_transform_unit.sv
`timescale 1ns / 1ps
// Testbench top for homogeneous_transform_unit: directed and random beats with bursty
// sending and a stalling receiver; htu_checker does prediction and comparison.
// Depends on htu_pkg, homogeneous_transform_unit and htu_checker.
module tb_homogeneous_transform_unit;
  import htu_pkg::*;

  typedef logic signed [17:0] trig_t;

  // one input beat, every field of the in channel
  typedef struct {
    op_t        op;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] axis;
    coef_t      value;
    trig_t      cosine;
    trig_t      sine;
    coef_t      vx;
    coef_t      vy;
    coef_t      vz;
    coef_t      vw;
  } beat_t;

  // receiver pacing styles
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CADENCE} rx_mode_t;

  localparam logic [1:0] AXIS_NONE = 2'd3;   // no axis: rotation zeroes, translation is identity
  localparam int RANDOM_BEATS = 1050;
  localparam int DIRECTED_BEATS = 25;
  localparam int HOLD_AT = 300;               // beat count that triggers the long receiver hold
  localparam int PAUSE_AT = 650;              // beat count where the sender drains the block
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         operation = '0;
  logic [1:0]         row = '0;
  logic [1:0]         col = '0;
  logic signed [31:0] value = '0;
  logic [1:0]         axis = '0;
  logic signed [17:0] cosine = '0;
  logic signed [17:0] sine = '0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic signed [31:0] vec_w = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               overflow;

  int pending;      // transform results still owed by the block
  int mismatches;   // failures seen by the checker

  // sender state
  int beats_sent = 0;
  int burst_left = 8;
  bit gapless = 1'b0;

  // hold requests travel from the sender to the receiver as a ticket count
  int hold_tickets = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stretch_left = 0;
  int cadence = 0;
  rx_mode_t rx_mode = RX_OPEN;

  int idle_cycles = 0;

  homogeneous_transform_unit DUT (.*);

  htu_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // random field values
  // ---------------------------------------------------------------------------

  // Q16.16 values: mostly modest magnitudes so results are not all saturated,
  // plus full-range words and the corner values
  function automatic coef_t rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return coef_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      5, 6:          return coef_t'($urandom);
      7:             return coef_t'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      default: begin
        case ($urandom_range(0, 6))
          0:       return COEF_MIN;
          1:       return COEF_MAX;
          2:       return '0;
          3:       return ONE;
          4:       return -ONE;
          5:       return 32'sd1;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // cosine/sine: usually within +-1.0, sometimes anything the 18-bit field holds
  function automatic trig_t rand_trig();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return trig_t'(int'($urandom_range(0, 131072)) - 65536);
      6, 7:             return trig_t'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return trig_t'(65536);
          1:       return trig_t'(-65536);
          2:       return trig_t'(-131072);
          3:       return trig_t'(131071);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // every field randomized, including the ones this operation ignores
  function automatic beat_t fresh(input op_t op);
    beat_t b;
    b.op     = op;
    b.row    = 2'($urandom_range(0, 3));
    b.col    = 2'($urandom_range(0, 3));
    b.axis   = 2'($urandom_range(0, 3));
    b.value  = rand_q();
    b.cosine = rand_trig();
    b.sine   = rand_trig();
    b.vx     = rand_q();
    b.vy     = rand_q();
    b.vz     = rand_q();
    b.vw     = rand_q();
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offer one beat, wait for the handshake, then maybe end the burst.
  // in_valid stays high across back-to-back beats and is only dropped for a gap.
  // ---------------------------------------------------------------------------
  task automatic put_beat(input beat_t b);
    operation <= b.op;
    row       <= b.row;
    col       <= b.col;
    axis      <= b.axis;
    value     <= b.value;
    cosine    <= b.cosine;
    sine      <= b.sine;
    vec_x     <= b.vx;
    vec_y     <= b.vy;
    vec_z     <= b.vz;
    vec_w     <= b.vw;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (!gapless) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        // mostly short bursts, now and then a long gap-free stretch
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end
    end
  endtask

  // stop offering and wait until every outstanding transform has come back;
  // the first edge lets the checker's count catch up with the last beat
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    beat_t b;
    bit    held;
    bit    paused;
    held   = 1'b0;
    paused = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ------------------------------------------------------
    // matrix is all zero straight out of reset
    b = fresh(OP_XFORM);
    b.vx = COEF_MAX; b.vy = COEF_MIN; b.vz = COEF_MAX; b.vw = COEF_MIN;
    put_beat(b);
    put_beat(fresh(OP_IDENT));
    b = fresh(OP_XFORM);
    b.vx = COEF_MAX; b.vy = COEF_MIN; b.vz = '0; b.vw = -32'sd1;
    put_beat(b);
    // large coefficients force saturation on both sides
    b = fresh(OP_WRITE);
    b.row = 2'd0; b.col = 2'd0; b.value = COEF_MAX;
    put_beat(b);
    b = fresh(OP_XFORM);
    b.vx = COEF_MAX; b.vy = ONE; b.vz = -ONE; b.vw = ONE;
    put_beat(b);
    b = fresh(OP_WRITE);
    b.row = 2'd1; b.col = 2'd1; b.value = COEF_MIN;
    put_beat(b);
    b = fresh(OP_WRITE);
    b.row = 2'd3; b.col = 2'd3; b.value = 32'sd1;
    put_beat(b);
    // w is a tiny negative product: must truncate to zero, not round down
    b = fresh(OP_XFORM);
    b.vx = COEF_MIN; b.vy = COEF_MAX; b.vz = '0; b.vw = -32'sd3;
    put_beat(b);

    // rotations on each axis, including trig terms beyond +-1.0 and no axis
    b = fresh(OP_ROTATE);
    b.axis = AXIS_X; b.cosine = trig_t'(65536); b.sine = trig_t'(-65536);
    put_beat(b);
    put_beat(fresh(OP_XFORM));
    b = fresh(OP_ROTATE);
    b.axis = AXIS_Y; b.cosine = trig_t'(-131072); b.sine = trig_t'(131071);
    put_beat(b);
    put_beat(fresh(OP_XFORM));
    b = fresh(OP_ROTATE);
    b.axis = AXIS_Z; b.cosine = trig_t'(46341); b.sine = trig_t'(-46341);
    put_beat(b);
    put_beat(fresh(OP_XFORM));
    b = fresh(OP_ROTATE);
    b.axis = AXIS_NONE; b.cosine = trig_t'(65536); b.sine = trig_t'(65536);
    put_beat(b);
    put_beat(fresh(OP_XFORM));

    // translation negate of the most negative distance saturates positive
    b = fresh(OP_TRANSLATE);
    b.axis = AXIS_Z; b.value = COEF_MIN;
    put_beat(b);
    put_beat(fresh(OP_NEG_TRANS));
    b = fresh(OP_XFORM);
    b.vw = ONE;
    put_beat(b);

    // translation with no axis is the identity; then an asymmetric transpose
    b = fresh(OP_TRANSLATE);
    b.axis = AXIS_NONE;
    put_beat(b);
    b = fresh(OP_WRITE);
    b.row = 2'd0; b.col = 2'd3; b.value = -(ONE * 5);
    put_beat(b);
    put_beat(fresh(OP_TRANSPOSE));
    put_beat(fresh(OP_XFORM));

    put_beat(fresh(OP_CLEAR));
    put_beat(fresh(OP_XFORM));

    // ---- random part --------------------------------------------------------
    while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
      if (!held && beats_sent >= HOLD_AT) begin
        // receiver goes quiet while we keep pushing transforms: the queue and
        // the MAC pipeline fill and in_ready has to drop
        held = 1'b1;
        hold_tickets <= hold_tickets + 1;
        gapless = 1'b1;
        repeat (24) put_beat(fresh(OP_XFORM));
        gapless = 1'b0;
      end
      if (!paused && beats_sent >= PAUSE_AT) begin
        paused = 1'b1;
        drain();
      end

      if ($urandom_range(0, 9) < 7) begin
        // well-formed: set up a matrix, then run a few vectors through it
        case ($urandom_range(0, 5))
          0: put_beat(fresh(OP_IDENT));
          1: begin
            b = fresh(OP_ROTATE);
            b.axis = 2'($urandom_range(0, 2));
            put_beat(b);
          end
          2: begin
            b = fresh(OP_TRANSLATE);
            b.axis = 2'($urandom_range(0, 2));
            put_beat(b);
          end
          3: begin
            put_beat(fresh(OP_IDENT));
            repeat ($urandom_range(1, 4)) put_beat(fresh(OP_WRITE));
          end
          4: begin
            b = fresh(OP_ROTATE);
            b.axis = 2'($urandom_range(0, 2));
            put_beat(b);
            put_beat(fresh(OP_TRANSPOSE));
          end
          default: begin
            b = fresh(OP_TRANSLATE);
            b.axis = 2'($urandom_range(0, 2));
            put_beat(b);
            put_beat(fresh(OP_NEG_TRANS));
          end
        endcase
        repeat ($urandom_range(1, 8)) put_beat(fresh(OP_XFORM));
      end else begin
        // noise: any operation with any field values
        repeat ($urandom_range(1, 4)) put_beat(fresh(op_t'($urandom_range(0, 7))));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: changes pacing style every stretch; a hold ticket from the sender
  // forces out_ready low for HOLD_CYCLES, counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_tickets != hold_seen) begin
      hold_seen = hold_tickets;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        stretch_left = $urandom_range(10, 80);
      end
      stretch_left--;
      cadence++;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_LIGHT:   out_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:   out_ready <= ($urandom_range(0, 3) == 0);
        default:    out_ready <= (cadence % 3 != 0);
      endcase
    end
  end

  // watchdog: too long without any beat on either channel means the block hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

>>> homogeneous_transform_unit.f
hw/rtl/htu_pkg.sv
hw/rtl/htu_front.sv
hw/rtl/htu_queue.sv
hw/rtl/htu_matrix.sv
hw/rtl/htu_mac.sv
hw/rtl/homogeneous_transform_unit.sv
hw/rtl/htu_checker.sv
sim/htu_checker.sv
sim/tb_homogeneous_transform_unit.sv
